### hdl/bdeq_pkg.sv
package bdeq_pkg;

    localparam int OP_W               = 3;
    localparam int FIELD_W            = 32;
    localparam int CAP_W              = 11;
    localparam int COUNT_W            = 11;
    localparam int DEPTH_DEFAULT      = 1024;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [FIELD_W-1:0] value;
    } bdeq_req_t;

    typedef struct packed {
        logic                      accepted;
        logic signed [FIELD_W-1:0] front_value;
        logic signed [FIELD_W-1:0] rear_value;
        logic                      is_empty;
        logic                      is_full;
        logic [COUNT_W-1:0]        entry_count;
    } bdeq_rsp_t;

endpackage

### hdl/bounded_double_ended_queue.sv
// double-ended queue on a ring buffer of DEPTH entries with a capacity register
// (reset 1024, limited to DEPTH). each request passes through the accept cycle,
// in which the ring memory is written or read, and the busy state, in which the
// registered memory read data is used and the response is loaded into the output
// register. a new request is taken only once the previous response is loaded; a
// response still waiting in the output register holds the next request in its
// busy state. front and rear entries are cached in registers, so only a pop that
// leaves two or more entries needs the memory read. capacity must be written
// through the cfg channel only while no request is in progress; the block does
// not enforce this. a write does not clear the queue.
module bounded_double_ended_queue #(
    parameter int DEPTH      = bdeq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = bdeq_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bdeq_pkg::bdeq_req_t           in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bdeq_pkg::bdeq_rsp_t           out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bdeq_pkg::CAP_W-1:0]    cfg_data
);
    import bdeq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CMP_W-1:0] DEPTH_C  = CMP_W'(DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic [DATA_WIDTH-1:0] ring_mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic                  state_reg, state_next;
    logic [CAP_W-1:0]      cap_reg;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DATA_WIDTH-1:0] front_reg, front_next;
    logic [DATA_WIDTH-1:0] rear_reg, rear_next;
    logic                  pend_front_reg, pend_front_next;
    logic                  pend_rear_reg, pend_rear_next;
    logic                  ok_reg, ok_next;
    logic                  out_valid_reg, out_valid_next;
    bdeq_rsp_t             out_data_reg, out_data_next;

    logic                  wr_en, rd_en;
    logic [IDX_W-1:0]      wr_addr, rd_addr;
    logic [DATA_WIDTH-1:0] wr_data;

    logic                  accept, finish;
    logic [CMP_W-1:0]      cnt_w, cap_w, eff_cap;
    logic                  room, any;
    logic [DATA_WIDTH-1:0] front_res, rear_res;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        return (i == IDX_LAST) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_LAST : i - 1'b1;
    endfunction

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign accept  = in_valid && in_ready;
    assign finish  = (state_reg == ST_BUSY) && (!out_valid_reg || out_ready);

    assign cnt_w   = CMP_W'(count_reg);
    assign cap_w   = CMP_W'(cap_reg);
    assign eff_cap = (cap_w > DEPTH_C) ? DEPTH_C : cap_w;
    assign room    = cnt_w < eff_cap;
    assign any     = (count_reg != '0);
    assign wr_data = DATA_WIDTH'($unsigned(in_data.value));

    // request decode and index update at accept, front/rear cache update at finish
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        front_next      = front_reg;
        rear_next       = rear_reg;
        pend_front_next = pend_front_reg;
        pend_rear_next  = pend_rear_reg;
        ok_next         = ok_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        wr_addr         = head_reg;
        rd_addr         = head_reg;

        if (accept)
        begin
            ok_next         = 1'b1;
            pend_front_next = 1'b0;
            pend_rear_next  = 1'b0;
            case (in_data.operation)
                OP_PUSH_FRONT:
                begin
                    if (room)
                    begin
                        head_next  = ring_prev(head_reg);
                        wr_en      = 1'b1;
                        wr_addr    = ring_prev(head_reg);
                        count_next = count_reg + 1'b1;
                        front_next = wr_data;
                        if (!any)
                        begin
                            rear_next = wr_data;
                        end
                    end
                    else
                    begin
                        ok_next = 1'b0;
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (room)
                    begin
                        tail_next  = ring_next(tail_reg);
                        wr_en      = 1'b1;
                        wr_addr    = tail_reg;
                        count_next = count_reg + 1'b1;
                        rear_next  = wr_data;
                        if (!any)
                        begin
                            front_next = wr_data;
                        end
                    end
                    else
                    begin
                        ok_next = 1'b0;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (any)
                    begin
                        head_next  = ring_next(head_reg);
                        count_next = count_reg - 1'b1;
                        // one left: it is the cached rear
                        if (cnt_w == CMP_W'(2))
                        begin
                            front_next = rear_reg;
                        end
                        else if (cnt_w > CMP_W'(2))
                        begin
                            rd_en           = 1'b1;
                            rd_addr         = ring_next(head_reg);
                            pend_front_next = 1'b1;
                        end
                    end
                    else
                    begin
                        ok_next = 1'b0;
                    end
                end
                OP_POP_BACK:
                begin
                    if (any)
                    begin
                        tail_next  = ring_prev(tail_reg);
                        count_next = count_reg - 1'b1;
                        if (cnt_w == CMP_W'(2))
                        begin
                            rear_next = front_reg;
                        end
                        else if (cnt_w > CMP_W'(2))
                        begin
                            rd_en          = 1'b1;
                            rd_addr        = ring_prev(ring_prev(tail_reg));
                            pend_rear_next = 1'b1;
                        end
                    end
                    else
                    begin
                        ok_next = 1'b0;
                    end
                end
                default:
                begin
                    ok_next = 1'b1;
                end
            endcase
        end
        else if (finish)
        begin
            front_next      = front_res;
            rear_next       = rear_res;
            pend_front_next = 1'b0;
            pend_rear_next  = 1'b0;
        end
    end

    assign front_res = pend_front_reg ? rd_data_reg : front_reg;
    assign rear_res  = pend_rear_reg  ? rd_data_reg : rear_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (finish)
                begin
                    state_next                = ST_IDLE;
                    out_valid_next            = 1'b1;
                    out_data_next.accepted    = ok_reg;
                    out_data_next.is_empty    = !any;
                    out_data_next.is_full     = (cnt_w >= eff_cap);
                    out_data_next.entry_count = COUNT_W'(count_reg);
                    if (any)
                    begin
                        out_data_next.front_value = FIELD_W'(front_res);
                        out_data_next.rear_value  = FIELD_W'(rear_res);
                    end
                    else
                    begin
                        out_data_next.front_value = FIELD_W'({DATA_WIDTH{1'b1}});
                        out_data_next.rear_value  = FIELD_W'({DATA_WIDTH{1'b1}});
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cap_reg        <= CAP_RESET;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            pend_front_reg <= 1'b0;
            pend_rear_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            pend_front_reg <= pend_front_next;
            pend_rear_reg  <= pend_rear_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg    <= front_next;
        rear_reg     <= rear_next;
        ok_reg       <= ok_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

endmodule

### hdl/bdeq_checker.sv
module bdeq_sva (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input bdeq_pkg::bdeq_rsp_t out_data
);
    import bdeq_pkg::*;

    // a stalled response holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("response changed while stalled");

    // one request in flight at a time
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous one in progress");

    // an empty queue reports no entries
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_empty |-> out_data.entry_count == '0)
        else $error("empty flag with nonzero entry count");

    // a request accepted while no response is waiting gets its response without stall
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> ##1 out_valid)
        else $error("response missing after request");

endmodule

bind bounded_double_ended_queue bdeq_sva u_bdeq_sva (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
